>>> rtl/salc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types and constants of the steering angle loss compensator: number
// widths, register indexes, reset values and the arithmetic unit interface.
// ----------------------------------------------------------------------------
package salc_pkg;

  // Number formats
  localparam int unsigned ANGLE_W = 16;  // Q7.8 angle
  localparam int unsigned TREND_W = 24;  // Q7.16 trend rate
  localparam int unsigned MAG_W   = 24;  // magnitude operand of the shared unit
  localparam int unsigned OPB_W   = 16;  // second operand (decay or blend factor)
  localparam int unsigned DIV_W   = 8;   // divisor width (blend length)
  localparam int unsigned PROD_W  = MAG_W + OPB_W;
  localparam int unsigned DECAY_SH = 16; // Q0.16 scaling of the decays

  localparam int unsigned MUL_STEPS = OPB_W;
  localparam int unsigned DIV_STEPS = MAG_W;
  localparam int unsigned CNT_W     = 5;

  localparam logic signed [ANGLE_W:0] ANGLE_LIMIT = 17'sd20480;  // 80 degrees
  localparam logic [7:0] LOST_SAT = 8'd255;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_FRAMES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TREND_FRAMES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_DECAY   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_DECAY   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TREND_ENABLE = 3'd5;
  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values
  localparam logic [14:0] RST_MAX_STEP     = 15'd1280;
  localparam logic [7:0]  RST_BLEND_FRAMES = 8'd5;
  localparam logic [7:0]  RST_TREND_FRAMES = 8'd10;
  localparam logic [15:0] RST_RATE_DECAY   = 16'd58982;
  localparam logic [15:0] RST_ZERO_DECAY   = 16'd62259;
  localparam logic        RST_TREND_ENABLE = 1'b1;

  // Shared unit operations
  typedef enum logic {
    OP_MUL,
    OP_DIV
  } salc_op_e;

  typedef struct packed {
    logic             start;
    salc_op_e         op;
    logic [MAG_W-1:0] a;
    logic [OPB_W-1:0] b;
  } salc_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [PROD_W-1:0] res;
  } salc_rsp_t;

endpackage

>>> rtl/steering_angle_loss_compensator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// steering_angle_loss_compensator
// Compensates one steering angle per frame: trend tracking on valid frames,
// hold, trend extrapolation or decay to zero while lost, and a linear blend
// on reacquisition. All multiplies and the blend divide run on salc_mdu.
// ----------------------------------------------------------------------------
// Work per frame: first, hold and plain valid frames need no arithmetic;
// extrapolating from the trend takes one 16-step multiply; decaying toward
// zero takes two 16-step multiplies; a blend frame takes a 16-step multiply
// then a 24-step divide. Input is taken again in the cycle after the result
// is loaded, and no new frame is taken before that.
// Reset (rst_ni low, asynchronous) loads register defaults and clears state.
// ----------------------------------------------------------------------------
module steering_angle_loss_compensator (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [salc_pkg::ANGLE_W-1:0]  measured_angle_i,
  input  logic                                 measure_valid_i,
  input  logic                                 extrap_allowed_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [salc_pkg::ANGLE_W-1:0]  out_angle_o,
  input  logic                                 cfg_we_i,
  input  logic [salc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [salc_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);
  import salc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_BL_MUL,
    ST_BL_DIV,
    ST_EX_ZERO,
    ST_EX_RATE,
    ST_FINISH
  } seq_state_e;

  // Configuration registers
  logic [14:0] max_step_q;
  logic [7:0]  blend_frames_q;
  logic [7:0]  trend_frames_q;
  logic [15:0] rate_decay_q;
  logic [15:0] zero_decay_q;
  logic        trend_en_q;

  // Sequencer and block state
  seq_state_e                state_q, state_d;
  logic signed [ANGLE_W-1:0] meas_q;
  logic                      mvalid_q, allow_q;
  logic                      seen_q, seen_d;
  logic signed [ANGLE_W-1:0] prev_meas_q, prev_meas_d;
  logic signed [ANGLE_W-1:0] prev_out_q, prev_out_d;
  logic signed [TREND_W-1:0] trend_q, trend_d;
  logic signed [ANGLE_W-1:0] origin_q, origin_d;
  logic [7:0]                lost_q, lost_d;
  logic [7:0]                left_q, left_d;
  logic signed [ANGLE_W:0]   work_o_q, work_o_d;
  logic                      neg_q, neg_d;
  logic signed [ANGLE_W-1:0] res_q, res_d;
  logic                      out_valid_q, out_valid_d;
  logic signed [ANGLE_W-1:0] out_angle_q, out_angle_d;

  salc_req_t mdu_req;
  salc_rsp_t mdu_rsp;

  // Valid-frame trend update
  logic signed [ANGLE_W:0]   meas_x, pmeas_x, pout_x, diff, maxs, step_c;
  logic signed [TREND_W+1:0] step_w, trend_w, tsum, thalf;
  logic signed [TREND_W-1:0] trend_half;

  // Blend set-up
  logic signed [ANGLE_W-1:0] origin_new;
  logic [7:0]                left_new, left_eff, blend_k;
  logic signed [ANGLE_W:0]   bdiff;
  logic [ANGLE_W:0]          bmag;

  // Extrapolation set-up
  logic signed [TREND_W-1:0] lim, rc;
  logic [TREND_W-1:0]        rmag, tmag;
  logic [ANGLE_W-1:0]        rsh, pmag;
  logic signed [ANGLE_W:0]   rsh_s, o_ext;

  // Results of the shared unit
  logic [ANGLE_W-1:0]        zm;
  logic signed [ANGLE_W:0]   zo;
  logic [TREND_W-1:0]        rm;
  logic signed [TREND_W-1:0] trend_dec;
  logic [ANGLE_W:0]          bq;
  logic signed [ANGLE_W+1:0] bres;
  logic signed [ANGLE_W-1:0] o_clip;
  logic [7:0]                lost_inc;

  assign meas_x  = {meas_q[ANGLE_W-1], meas_q};
  assign pmeas_x = {prev_meas_q[ANGLE_W-1], prev_meas_q};
  assign pout_x  = {prev_out_q[ANGLE_W-1], prev_out_q};

  // Clip the step and halve the new trend, truncating toward zero
  assign diff    = meas_x - pmeas_x;
  assign maxs    = $signed({2'b00, max_step_q});
  assign step_c  = (diff > maxs) ? maxs : ((diff < -maxs) ? -maxs : diff);
  assign step_w  = $signed({step_c[ANGLE_W], step_c, 8'h00});
  assign trend_w = $signed({{2{trend_q[TREND_W-1]}}, trend_q});
  assign tsum    = trend_w + step_w;
  assign thalf   = (tsum + $signed({{(TREND_W+1){1'b0}}, tsum[TREND_W+1]})) >>> 1;
  assign trend_half = thalf[TREND_W-1:0];

  // Blend origin, remaining frames and weight
  assign origin_new = (lost_q != 8'd0) ? prev_out_q : origin_q;
  assign left_new   = (lost_q != 8'd0) ? blend_frames_q : left_q;
  assign left_eff   = (left_new > blend_frames_q) ? blend_frames_q : left_new;
  assign blend_k    = blend_frames_q - left_eff + 8'd1;
  assign bdiff      = meas_x - $signed({origin_new[ANGLE_W-1], origin_new});
  assign bmag       = bdiff[ANGLE_W] ? (ANGLE_W+1)'(-bdiff) : bdiff;

  // Clipped trend and one extrapolation step
  assign lim   = $signed({1'b0, max_step_q, 8'h00});
  assign rc    = (trend_q > lim) ? lim : ((trend_q < -lim) ? -lim : trend_q);
  assign rmag  = trend_q[TREND_W-1] ? TREND_W'(-rc) : rc;
  assign tmag  = trend_q[TREND_W-1] ? TREND_W'(-trend_q) : trend_q;
  assign rsh   = rmag[TREND_W-1:8];
  assign rsh_s = trend_q[TREND_W-1] ? -$signed({1'b0, rsh}) : $signed({1'b0, rsh});
  assign o_ext = pout_x + rsh_s;
  assign pmag  = prev_out_q[ANGLE_W-1] ? ANGLE_W'(-prev_out_q) : prev_out_q;

  // Apply signs to the unit's magnitudes
  assign zm        = mdu_rsp.res[DECAY_SH+ANGLE_W-1:DECAY_SH];
  assign zo        = prev_out_q[ANGLE_W-1] ? -$signed({1'b0, zm}) : $signed({1'b0, zm});
  assign rm        = mdu_rsp.res[DECAY_SH+TREND_W-1:DECAY_SH];
  assign trend_dec = trend_q[TREND_W-1] ? TREND_W'(-rm) : rm;
  assign bq        = mdu_rsp.res[ANGLE_W:0];
  assign bres      = $signed({{2{origin_q[ANGLE_W-1]}}, origin_q})
                   + (neg_q ? -$signed({1'b0, bq}) : $signed({1'b0, bq}));
  assign o_clip    = (work_o_q > ANGLE_LIMIT) ? ANGLE_W'(ANGLE_LIMIT)
                   : ((work_o_q < -ANGLE_LIMIT) ? ANGLE_W'(-ANGLE_LIMIT)
                   : work_o_q[ANGLE_W-1:0]);
  assign lost_inc  = (lost_q == LOST_SAT) ? lost_q : lost_q + 8'd1;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    seen_d      = seen_q;
    prev_meas_d = prev_meas_q;
    prev_out_d  = prev_out_q;
    trend_d     = trend_q;
    origin_d    = origin_q;
    lost_d      = lost_q;
    left_d      = left_q;
    work_o_d    = work_o_q;
    neg_d       = neg_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_angle_d = out_angle_q;
    mdu_req     = '{start: 1'b0, op: OP_MUL, a: '0, b: '0};

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        state_d = ST_FINISH;
        if (mvalid_q) begin
          if (!seen_q) begin
            seen_d      = 1'b1;
            prev_meas_d = meas_q;
            prev_out_d  = meas_q;
            trend_d     = '0;
            lost_d      = '0;
            left_d      = '0;
            res_d       = meas_q;
          end else begin
            origin_d    = origin_new;
            lost_d      = '0;
            trend_d     = trend_half;
            prev_meas_d = meas_q;
            res_d       = meas_q;
            prev_out_d  = meas_q;
            left_d      = left_new;
            if (left_new != 8'd0) begin
              if (blend_frames_q == 8'd0) begin
                left_d = '0;
              end else begin
                left_d      = left_eff - 8'd1;
                neg_d       = bdiff[ANGLE_W];
                mdu_req     = '{start: 1'b1, op: OP_MUL,
                                a: MAG_W'(bmag), b: OPB_W'(blend_k)};
                state_d     = ST_BL_MUL;
              end
            end
          end
        end else if (!seen_q) begin
          res_d = '0;
        end else if (!allow_q || !trend_en_q) begin
          prev_out_d = prev_meas_q;
          lost_d     = lost_inc;
          res_d      = prev_meas_q;
        end else if (lost_q < trend_frames_q) begin
          work_o_d = o_ext;
          mdu_req  = '{start: 1'b1, op: OP_MUL, a: rmag, b: rate_decay_q};
          state_d  = ST_EX_RATE;
        end else begin
          mdu_req = '{start: 1'b1, op: OP_MUL, a: MAG_W'(pmag), b: zero_decay_q};
          state_d = ST_EX_ZERO;
        end
      end
      ST_BL_MUL: begin
        if (mdu_rsp.done) begin
          mdu_req = '{start: 1'b1, op: OP_DIV, a: mdu_rsp.res[MAG_W-1:0],
                      b: OPB_W'(blend_frames_q)};
          state_d = ST_BL_DIV;
        end
      end
      ST_BL_DIV: begin
        if (mdu_rsp.done) begin
          res_d      = bres[ANGLE_W-1:0];
          prev_out_d = bres[ANGLE_W-1:0];
          state_d    = ST_FINISH;
        end
      end
      ST_EX_ZERO: begin
        if (mdu_rsp.done) begin
          work_o_d = zo;
          mdu_req  = '{start: 1'b1, op: OP_MUL, a: tmag, b: rate_decay_q};
          state_d  = ST_EX_RATE;
        end
      end
      ST_EX_RATE: begin
        if (mdu_rsp.done) begin
          trend_d    = trend_dec;
          lost_d     = lost_inc;
          prev_out_d = o_clip;
          res_d      = o_clip;
          state_d    = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Load the output register once it is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_angle_d = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seen_q      <= 1'b0;
      prev_meas_q <= '0;
      prev_out_q  <= '0;
      trend_q     <= '0;
      origin_q    <= '0;
      lost_q      <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seen_q      <= seen_d;
      prev_meas_q <= prev_meas_d;
      prev_out_q  <= prev_out_d;
      trend_q     <= trend_d;
      origin_q    <= origin_d;
      lost_q      <= lost_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      meas_q   <= measured_angle_i;
      mvalid_q <= measure_valid_i;
      allow_q  <= extrap_allowed_i;
    end
    work_o_q    <= work_o_d;
    neg_q       <= neg_d;
    res_q       <= res_d;
    out_angle_q <= out_angle_d;
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_step_q     <= RST_MAX_STEP;
      blend_frames_q <= RST_BLEND_FRAMES;
      trend_frames_q <= RST_TREND_FRAMES;
      rate_decay_q   <= RST_RATE_DECAY;
      zero_decay_q   <= RST_ZERO_DECAY;
      trend_en_q     <= RST_TREND_ENABLE;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MAX_STEP:     max_step_q     <= cfg_wdata_i[14:0];
        CFG_BLEND_FRAMES: blend_frames_q <= cfg_wdata_i[7:0];
        CFG_TREND_FRAMES: trend_frames_q <= cfg_wdata_i[7:0];
        CFG_RATE_DECAY:   rate_decay_q   <= cfg_wdata_i;
        CFG_ZERO_DECAY:   zero_decay_q   <= cfg_wdata_i;
        CFG_TREND_ENABLE: trend_en_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  salc_mdu u_mdu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mdu_req),
    .rsp_o  (mdu_rsp)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_angle_o = out_angle_q;

  // Lost frames are only counted once a measurement has been seen
  a_lost_needs_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lost_q != 8'd0) |-> seen_q)
    else $error("lost count running before any valid measurement");

  // Trend and blend stay cleared until the first measurement
  a_clear_before_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seen_q |-> (trend_q == '0 && left_q == '0))
    else $error("trend or blend state set before any valid measurement");

  // The shared unit only finishes while the sequencer waits for it
  a_done_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mdu_rsp.done |-> (state_q == ST_BL_MUL || state_q == ST_BL_DIV ||
                      state_q == ST_EX_ZERO || state_q == ST_EX_RATE))
    else $error("arithmetic unit finished with no operation pending");

  // A transfer in starts evaluation on the next cycle
  a_accept_to_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_EVAL && !mdu_rsp.busy))
    else $error("accepted item did not enter evaluation");

endmodule

>>> rtl/salc_mdu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_mdu
// Iterative multiply / divide unit on magnitudes. A multiply gives the full
// product a*b, one bit of b per cycle; a divide gives a / b[7:0] truncated,
// one quotient bit per cycle (restoring). done pulses for one cycle.
// ----------------------------------------------------------------------------
module salc_mdu (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  salc_pkg::salc_req_t req_i,
  output salc_pkg::salc_rsp_t rsp_o
);
  import salc_pkg::*;

  typedef enum logic {
    MS_IDLE,
    MS_RUN
  } mdu_state_e;

  mdu_state_e       state_q;
  salc_op_e         op_q;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [MAG_W-1:0] a_q;
  logic [DIV_W-1:0] d_q;
  logic [PROD_W:0]  prod_q;
  logic [DIV_W-1:0] rem_q;
  logic [MAG_W-1:0] quo_q;

  logic [MAG_W+1:0] mul_sum;
  logic [PROD_W:0]  mul_next;
  logic [DIV_W:0]   div_trial;
  logic             div_ge;
  logic [DIV_W:0]   div_diff;

  // Add the multiplicand into the upper half when the low bit is set
  assign mul_sum  = {1'b0, prod_q[PROD_W:OPB_W]} + (prod_q[0] ? {2'b00, a_q} : '0);
  assign mul_next = {mul_sum, prod_q[OPB_W-1:1]};

  // Restoring division step
  assign div_trial = {rem_q, quo_q[MAG_W-1]};
  assign div_ge    = (div_trial >= {1'b0, d_q});
  assign div_diff  = div_trial - {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MS_IDLE;
      op_q    <= OP_MUL;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        MS_IDLE: begin
          if (req_i.start) begin
            state_q <= MS_RUN;
            op_q    <= req_i.op;
            cnt_q   <= (req_i.op == OP_MUL) ? CNT_W'(MUL_STEPS - 1) : CNT_W'(DIV_STEPS - 1);
          end
        end
        MS_RUN: begin
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == '0) begin
            state_q <= MS_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: state_q <= MS_IDLE;
      endcase
    end
  end

  // Operand and working registers
  always_ff @(posedge clk_i) begin
    if (state_q == MS_IDLE) begin
      if (req_i.start) begin
        a_q    <= req_i.a;
        d_q    <= req_i.b[DIV_W-1:0];
        prod_q <= {{(MAG_W+1){1'b0}}, req_i.b};
        quo_q  <= req_i.a;
        rem_q  <= '0;
      end
    end else if (op_q == OP_MUL) begin
      prod_q <= mul_next;
    end else begin
      rem_q <= div_ge ? div_diff[DIV_W-1:0] : div_trial[DIV_W-1:0];
      quo_q <= {quo_q[MAG_W-2:0], div_ge};
    end
  end

  assign rsp_o.busy = (state_q == MS_RUN);
  assign rsp_o.done = done_q;
  assign rsp_o.res  = (op_q == OP_MUL) ? prod_q[PROD_W-1:0]
                                       : {{(PROD_W-MAG_W){1'b0}}, quo_q};

endmodule

>>> tb/tb_steering_angle_loss_compensator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_steering_angle_loss_compensator
// Self-checking bench for the steering angle loss compensator. A scoreboard
// class predicts each compensated angle from every accepted frame, then
// compares results in order. A short directed run covers start-up, hold,
// trend extrapolation, decay to zero, clipping and the reacquisition blend.
// Randomised phases follow, each with its own register settings and
// handshake gaps, plus a long output stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_steering_angle_loss_compensator;
  import salc_pkg::*;

  typedef enum int {
    GAPS_NONE,
    GAPS_SENDER,
    GAPS_RECEIVER,
    GAPS_BOTH
  } gap_mode_e;

  // Tracks the block's state and checks each output angle in order
  class angle_scoreboard;
    logic [14:0] max_step;
    logic [7:0]  blend_len;
    logic [7:0]  extrap_len;
    logic [15:0] rate_decay;
    logic [15:0] zero_decay;
    logic        trend_en;

    bit          seen;
    longint      prev_angle;
    longint      prev_result;
    longint      rate;
    longint      origin;
    int unsigned lost;
    int unsigned blend_left;

    logic signed [ANGLE_W-1:0] expected_angles[$];
    int unsigned mismatches;

    function new();
      max_step    = RST_MAX_STEP;
      blend_len   = RST_BLEND_FRAMES;
      extrap_len  = RST_TREND_FRAMES;
      rate_decay  = RST_RATE_DECAY;
      zero_decay  = RST_ZERO_DECAY;
      trend_en    = RST_TREND_ENABLE;
      seen        = 1'b0;
      prev_angle  = 0;
      prev_result = 0;
      rate        = 0;
      origin      = 0;
      lost        = 0;
      blend_left  = 0;
      mismatches  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_MAX_STEP:     max_step   = val[14:0];
        CFG_BLEND_FRAMES: blend_len  = val[7:0];
        CFG_TREND_FRAMES: extrap_len = val[7:0];
        CFG_RATE_DECAY:   rate_decay = val;
        CFG_ZERO_DECAY:   zero_decay = val;
        CFG_TREND_ENABLE: trend_en   = val[0];
        default: ;
      endcase
    endfunction

    // Arithmetic shift that rounds toward zero
    function longint trunc_shift(longint x, int n);
      return (x >= 0) ? (x >>> n) : -((-x) >>> n);
    endfunction

    function longint clamp(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function void count_lost();
      if (lost < LOST_SAT) lost++;
    endfunction

    // Advance the state by one frame and queue the angle it gives
    function void note_frame(logic signed [ANGLE_W-1:0] angle, logic mv, logic ea);
      longint m;
      longint step;
      longint o;
      longint r;
      longint k;
      longint res;
      m = angle;
      if (mv) begin
        if (!seen) begin
          seen        = 1'b1;
          prev_angle  = m;
          prev_result = m;
          rate        = 0;
          lost        = 0;
          blend_left  = 0;
          res         = m;
        end else begin
          // reacquired: start a blend from the last output
          if (lost > 0) begin
            origin     = prev_result;
            blend_left = blend_len;
            lost       = 0;
          end
          step       = clamp(m - prev_angle, longint'(max_step));
          rate       = trunc_shift(rate + step * 256, 1);
          prev_angle = m;
          res        = m;
          if (blend_left > 0) begin
            if (blend_len == 0) begin
              blend_left = 0;
            end else begin
              if (blend_left > blend_len) blend_left = blend_len;
              k   = longint'(blend_len) - longint'(blend_left) + 1;
              res = origin + (m - origin) * k / longint'(blend_len);
              blend_left--;
            end
          end
          prev_result = res;
        end
      end else if (!seen) begin
        res = 0;
      end else if (!ea || !trend_en) begin
        // hold the last measurement
        prev_result = prev_angle;
        count_lost();
        res = prev_result;
      end else begin
        o = prev_result;
        r = rate;
        if (lost < extrap_len) begin
          r = clamp(r, longint'(max_step) * 256);
          o = o + trunc_shift(r, 8);
        end else begin
          o = trunc_shift(o * longint'(zero_decay), 16);
        end
        rate = trunc_shift(r * longint'(rate_decay), 16);
        count_lost();
        o           = clamp(o, longint'(ANGLE_LIMIT));
        prev_result = o;
        res         = o;
      end
      expected_angles.push_back(res[ANGLE_W-1:0]);
    endfunction

    function void report(string what, longint exp_val, longint got_val);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s: expected %0d, got %0d", $time, what, exp_val, got_val);
      end
    endfunction

    function void check_result(logic signed [ANGLE_W-1:0] got);
      logic signed [ANGLE_W-1:0] exp_angle;
      if (expected_angles.size() == 0) begin
        report("out_angle with no frame pending", 0, got);
      end else begin
        exp_angle = expected_angles.pop_front();
        if (got !== exp_angle) report("out_angle mismatch", exp_angle, got);
      end
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic signed [ANGLE_W-1:0]   measured_angle_i;
  logic                        measure_valid_i;
  logic                        extrap_allowed_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic signed [ANGLE_W-1:0]   out_angle_o;
  logic                        cfg_we_i;
  logic [CFG_IDX_W-1:0]        cfg_index_i;
  logic [CFG_DATA_W-1:0]       cfg_wdata_i;

  angle_scoreboard sb;
  int unsigned     send_gap_pct;
  int unsigned     stall_pct;
  int unsigned     hold_cycles;
  int              walk_angle;

  steering_angle_loss_compensator u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .measured_angle_i (measured_angle_i),
    .measure_valid_i  (measure_valid_i),
    .extrap_allowed_i (extrap_allowed_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_angle_o      (out_angle_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Generous upper bound on the whole run
  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Output side: random stalls, or a long hold-off while hold_cycles runs down
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Check every result transfer
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_angle_o);
  end

  task automatic set_gaps(gap_mode_e mode);
    case (mode)
      GAPS_NONE:     begin send_gap_pct = 0;  stall_pct = 0;  end
      GAPS_SENDER:   begin send_gap_pct = 71; stall_pct = 0;  end
      GAPS_RECEIVER: begin send_gap_pct = 0;  stall_pct = 71; end
      default:       begin send_gap_pct = 11; stall_pct = 11; end
    endcase
  endtask

  // Offer one frame and hold it until the transfer; returns at a falling edge
  task automatic send_frame(logic signed [ANGLE_W-1:0] angle, logic mv, logic ea);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
      while ($urandom_range(99) < send_gap_pct) @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    measured_angle_i <= angle;
    measure_valid_i  <= mv;
    extrap_allowed_i <= ea;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_frame(angle, mv, ea);
    @(negedge clk_i);
  endtask

  task automatic stop_sending();
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.expected_angles.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    sb.write_reg(idx, val);
    @(negedge clk_i);
  endtask

  task automatic configure(int unsigned ms, int unsigned bf, int unsigned tf,
                           int unsigned rd, int unsigned zd, int unsigned te);
    write_reg(CFG_MAX_STEP, CFG_DATA_W'(ms));
    write_reg(CFG_BLEND_FRAMES, CFG_DATA_W'(bf));
    write_reg(CFG_TREND_FRAMES, CFG_DATA_W'(tf));
    write_reg(CFG_RATE_DECAY, CFG_DATA_W'(rd));
    write_reg(CFG_ZERO_DECAY, CFG_DATA_W'(zd));
    write_reg(CFG_TREND_ENABLE, CFG_DATA_W'(te));
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Measured angle: mostly a random walk, sometimes extremes or anything
  function automatic logic signed [ANGLE_W-1:0] pick_angle();
    int span;
    case ($urandom_range(9))
      0: return ANGLE_W'($urandom);
      1: begin
        case ($urandom_range(4))
          0: return 16'sh7fff;
          1: return 16'sh8000;
          2: return 16'sd20480;
          3: return -16'sd20480;
          default: return 16'sd0;
        endcase
      end
      default: begin
        span = ($urandom_range(3) == 0) ? 3000 : 64;
        walk_angle = walk_angle + int'($urandom_range(2 * span)) - span;
        if (walk_angle > 32767) walk_angle = 32767;
        if (walk_angle < -32768) walk_angle = -32768;
        return ANGLE_W'(walk_angle);
      end
    endcase
  endfunction

  // Runs of valid frames and of lost frames, with a little pure noise
  task automatic run_random(int unsigned n_frames);
    int unsigned sent;
    int unsigned kind;
    int unsigned len;
    sent = 0;
    while (sent < n_frames) begin
      kind = $urandom_range(9);
      if (kind < 5) begin
        len = $urandom_range(1, 12);
        repeat (len) send_frame(pick_angle(), 1'b1, 1'($urandom));
      end else if (kind < 9) begin
        len = $urandom_range(1, 20);
        repeat (len) send_frame(ANGLE_W'($urandom), 1'b0, ($urandom_range(99) < 85));
      end else begin
        len = $urandom_range(1, 4);
        repeat (len) send_frame(ANGLE_W'($urandom), 1'($urandom), 1'($urandom));
      end
      sent += len;
    end
  endtask

  initial begin
    sb               = new();
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    measured_angle_i = '0;
    measure_valid_i  = 1'b0;
    extrap_allowed_i = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_index_i      = CFG_MAX_STEP;
    cfg_wdata_i      = '0;
    hold_cycles      = 0;
    walk_angle       = 0;
    set_gaps(GAPS_NONE);
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: no measurement yet, first frame, clipped step
    send_frame(16'sh7fff, 1'b0, 1'b0);
    send_frame(16'sh8000, 1'b0, 1'b1);
    send_frame(16'sh8000, 1'b1, 1'b0);
    send_frame(16'sh7fff, 1'b1, 1'b1);
    // extrapolate past 80 degrees, then hold without clipping
    send_frame(16'sd0, 1'b0, 1'b1);
    send_frame(16'sd0, 1'b0, 1'b0);
    // extrapolate until the trend window ends, then decay toward zero
    repeat (10) send_frame(16'sh5555, 1'b0, 1'b1);
    // reacquire and blend
    send_frame(16'sd0, 1'b1, 1'b1);
    send_frame(16'sd256, 1'b1, 1'b0);
    send_frame(-16'sd256, 1'b1, 1'b1);
    send_frame(16'sd1000, 1'b1, 1'b0);
    send_frame(16'sd20480, 1'b1, 1'b1);
    send_frame(-16'sd20480, 1'b1, 1'b1);
    stop_sending();

    // Random phases, each with its own settings and gap pattern
    for (int p = 0; p < 8; p++) begin
      wait_drained();
      case (p)
        0: configure(1280, 5, 10, 58982, 62259, 1);
        1: configure(32767, 255, 255, 65535, 65535, 1);
        2: configure(0, 1, 0, 0, 0, 1);
        3: configure($urandom_range(32767), $urandom_range(1, 255), $urandom_range(255),
                     $urandom_range(65535), $urandom_range(65535), 0);
        4: configure($urandom_range(32767), 0, $urandom_range(255),
                     $urandom_range(65535), $urandom_range(65535), 1);
        5: configure($urandom_range(4000), 3, $urandom_range(20),
                     $urandom_range(65535), $urandom_range(65535), 1);
        default: configure($urandom_range(32767), $urandom_range(1, 255),
                           $urandom_range(40), $urandom_range(65535),
                           $urandom_range(65535), $urandom_range(1));
      endcase
      set_gaps(gap_mode_e'(p % 4));
      // long output hold-off while frames keep coming
      if (p == 2) hold_cycles = 400;
      run_random(145);
      // lost long enough for the lost counter to saturate
      if (p == 1) repeat (270) send_frame(ANGLE_W'($urandom), 1'b0, 1'b1);
      // leave a blend under way for the next settings
      send_frame(pick_angle(), 1'b0, 1'b1);
      send_frame(pick_angle(), 1'b1, 1'b1);
      send_frame(pick_angle(), 1'b1, 1'b0);
      stop_sending();
    end

    wait_drained();
    repeat (60) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.expected_angles.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
